// File: rtl/core/assert_macros.svh
// Assertion macros shared by the checksum parser RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TSP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TSP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/core/tsp_pkg.sv
// Package for the TCP segment parser and checksum block: beat and snapshot
// types, status codes, header word positions and the ones-complement adder.
// Depends on nothing.
package tsp_pkg;

  // Default upper bound on the segment length in bytes.
  localparam logic [31:0] MAX_SEG_BYTES_DEF = 32'd65535;

  // Smallest legal segment and data offset.
  localparam logic [31:0] MIN_SEG_BYTES = 32'd20;
  localparam logic [3:0]  MIN_OFFSET    = 4'd5;

  // Word positions of the fixed header.
  localparam logic [30:0] POS_SRC_PORT  = 31'd0;
  localparam logic [30:0] POS_DST_PORT  = 31'd1;
  localparam logic [30:0] POS_SEQ_HI    = 31'd2;
  localparam logic [30:0] POS_SEQ_LO    = 31'd3;
  localparam logic [30:0] POS_ACK_HI    = 31'd4;
  localparam logic [30:0] POS_ACK_LO    = 31'd5;
  localparam logic [30:0] POS_OFF_FLAGS = 31'd6;
  localparam logic [30:0] POS_WINDOW    = 31'd7;
  localparam logic [30:0] POS_CSUM      = 31'd8;
  localparam logic [30:0] POS_URGENT    = 31'd9;

  // Result status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_OFFSET    = 3'd2;
  localparam logic [2:0] ST_HDR_PAST  = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;
  localparam logic [2:0] ST_TOO_LONG  = 3'd5;

  // One input beat.
  typedef struct packed {
    logic        mode;
    logic [15:0] data_word;
    logic        single_byte;
    logic        last;
    logic [15:0] pseudo_sum;
    logic        ipv6;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] computed_checksum;
    logic [15:0] received_checksum;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [3:0]  data_offset;
    logic [8:0]  flags;
    logic [15:0] window_size;
    logic [15:0] urgent_pointer;
    logic [15:0] segment_bytes;
  } out_item_t;

  // Running segment state, also handed to the finishing stage as a snapshot.
  typedef struct packed {
    logic [15:0] sum;
    logic [31:0] cnt;
    logic        ipv6;
    logic        mode;
    logic [31:0] port_pair;
    logic [63:0] seq_ack;
    logic [15:0] off_flags;
    logic [15:0] window;
    logic [15:0] csum;
    logic [15:0] urgent;
  } snap_t;

  // Ones-complement add with end-around carry. The result never exceeds 16 bits.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// File: rtl/core/tsp_stream_if.sv
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload types come from tsp_pkg at instantiation.
interface tsp_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// File: rtl/core/tsp_accum.sv
// Input register, running ones-complement sum, byte count and header capture.
// Depends on tsp_pkg and tsp_stream_if.
module tsp_accum (
  input  logic           clk,
  input  logic           rst_n,
  tsp_stream_if.sink     in_ch,
  output tsp_pkg::snap_t snap_o,
  output logic           snap_vld_o,
  input  logic           snap_rdy_i
);

  logic              in_vld_r;
  tsp_pkg::in_item_t in_r;
  tsp_pkg::snap_t    acc_r;
  tsp_pkg::snap_t    snap_r;
  logic              snap_vld_r;

  logic              snap_free;
  logic              acc_go;
  logic              tail;
  logic [15:0]       word;
  logic [1:0]        nbytes;
  logic [30:0]       pos;
  logic [32:0]       cnt_ext;
  tsp_pkg::snap_t    upd;

  // Handshake: a beat moves on unless it is a last beat and the snapshot is busy.
  always_comb begin
    snap_free   = !snap_vld_r || snap_rdy_i;
    acc_go      = in_vld_r && (!in_r.last || snap_free);
    in_ch.ready = !in_vld_r || acc_go;
  end

  assign snap_o     = snap_r;
  assign snap_vld_o = snap_vld_r;

  // Fold the registered beat into the running state.
  always_comb begin
    tail    = in_r.last && in_r.single_byte;
    word    = tail ? {in_r.data_word[15:8], 8'h00} : in_r.data_word;
    nbytes  = tail ? 2'd1 : 2'd2;
    pos     = acc_r.cnt[31:1];
    upd     = acc_r;

    // A zero byte count marks the first beat of a segment.
    if (acc_r.cnt == '0) begin
      upd.sum  = in_r.pseudo_sum;
      upd.ipv6 = in_r.ipv6;
      upd.mode = in_r.mode;
    end

    case (pos)
      tsp_pkg::POS_SRC_PORT:  upd.port_pair[31:16] = word;
      tsp_pkg::POS_DST_PORT:  upd.port_pair[15:0]  = word;
      tsp_pkg::POS_SEQ_HI:    upd.seq_ack[63:48]   = word;
      tsp_pkg::POS_SEQ_LO:    upd.seq_ack[47:32]   = word;
      tsp_pkg::POS_ACK_HI:    upd.seq_ack[31:16]   = word;
      tsp_pkg::POS_ACK_LO:    upd.seq_ack[15:0]    = word;
      tsp_pkg::POS_OFF_FLAGS: upd.off_flags        = word;
      tsp_pkg::POS_WINDOW:    upd.window           = word;
      tsp_pkg::POS_CSUM:      upd.csum             = word;
      tsp_pkg::POS_URGENT:    upd.urgent           = word;
      default: ;
    endcase

    // The checksum field itself is left out of the sum.
    if (pos != tsp_pkg::POS_CSUM) begin
      upd.sum = tsp_pkg::oc_add(upd.sum, word);
    end

    // Byte count saturates at all ones.
    cnt_ext = {1'b0, acc_r.cnt} + {31'd0, nbytes};
    upd.cnt = cnt_ext[32] ? '1 : cnt_ext[31:0];
  end

  // Control and running state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      acc_r      <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_r <= in_ch.valid;
      end
      if (acc_go) begin
        acc_r <= in_r.last ? '0 : upd;
      end
      if (snap_free) begin
        snap_vld_r <= acc_go && in_r.last;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.data;
    end
    if (acc_go && in_r.last) begin
      snap_r <= upd;
    end
  end

endmodule

// File: rtl/core/tsp_final.sv
// Final fold of length into the sum, status checks and the result register.
// Depends on tsp_pkg and tsp_stream_if.
module tsp_final #(
  parameter logic [31:0] MAX_SEGMENT_BYTES = tsp_pkg::MAX_SEG_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tsp_pkg::snap_t snap_i,
  input  logic           snap_vld_i,
  output logic           snap_rdy_o,
  tsp_stream_if.source   out_ch
);

  logic               out_vld_r;
  tsp_pkg::out_item_t out_r;
  tsp_pkg::out_item_t res;
  logic [15:0]        sum_lo;
  logic [15:0]        sum_all;
  logic [15:0]        computed;
  logic [3:0]         offset;

  assign snap_rdy_o   = !out_vld_r || out_ch.ready;
  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;

  // Add the length, then the status checks in priority order.
  always_comb begin
    sum_lo   = tsp_pkg::oc_add(snap_i.sum, snap_i.cnt[15:0]);
    sum_all  = snap_i.ipv6 ? tsp_pkg::oc_add(sum_lo, snap_i.cnt[31:16]) : sum_lo;
    computed = ~sum_all;
    offset   = snap_i.off_flags[15:12];

    if (snap_i.cnt > MAX_SEGMENT_BYTES) begin
      res.status = tsp_pkg::ST_TOO_LONG;
    end else if (snap_i.cnt < tsp_pkg::MIN_SEG_BYTES) begin
      res.status = tsp_pkg::ST_SHORT;
    end else if (offset < tsp_pkg::MIN_OFFSET) begin
      res.status = tsp_pkg::ST_OFFSET;
    end else if ({26'd0, offset, 2'b00} > snap_i.cnt) begin
      res.status = tsp_pkg::ST_HDR_PAST;
    end else if (!snap_i.mode && (computed != snap_i.csum)) begin
      res.status = tsp_pkg::ST_MISMATCH;
    end else begin
      res.status = tsp_pkg::ST_OK;
    end

    res.computed_checksum = computed;
    res.received_checksum = snap_i.csum;
    res.source_port       = snap_i.port_pair[31:16];
    res.dest_port         = snap_i.port_pair[15:0];
    res.seq_number        = snap_i.seq_ack[63:32];
    res.ack_number        = snap_i.seq_ack[31:0];
    res.data_offset       = offset;
    res.flags             = snap_i.off_flags[8:0];
    res.window_size       = snap_i.window;
    res.urgent_pointer    = snap_i.urgent;
    res.segment_bytes     = (snap_i.cnt[31:16] != '0) ? 16'hffff : snap_i.cnt[15:0];
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (snap_rdy_o) begin
      out_vld_r <= snap_vld_i;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (snap_rdy_o && snap_vld_i) begin
      out_r <= res;
    end
  end

endmodule

// File: rtl/core/tcp_segment_parse_checksum.sv
// TCP segment parser and checksum. Takes one 16-bit word per cycle, back to back.
// The last word goes from the input register to the snapshot register, then to the
// result register. Throughput: one word per cycle.
// A stalled result side holds a last word in the input register and stalls the input.
// Reset (rst_n, synchronous, active low) clears all valid flags and segment state.
// Depends on tsp_pkg, tsp_stream_if, tsp_accum, tsp_final and assert_macros.svh.
`include "assert_macros.svh"

module tcp_segment_parse_checksum #(
  parameter logic [31:0] MAX_SEGMENT_BYTES = tsp_pkg::MAX_SEG_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  tsp_stream_if.sink   in_ch,
  tsp_stream_if.source out_ch
);

  tsp_pkg::snap_t snap;
  logic           snap_vld;
  logic           snap_rdy;
  logic           out_mismatch;
  logic           out_ok;
  logic           csum_differs;
  logic           hdr_short;

  // Running sum and header capture.
  tsp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .snap_o     (snap),
    .snap_vld_o (snap_vld),
    .snap_rdy_i (snap_rdy)
  );

  // Checksum finish and status.
  tsp_final #(
    .MAX_SEGMENT_BYTES (MAX_SEGMENT_BYTES)
  ) u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_i     (snap),
    .snap_vld_i (snap_vld),
    .snap_rdy_o (snap_rdy),
    .out_ch     (out_ch)
  );

  // Status decode of the result beat for the checks below.
  assign out_mismatch = out_ch.valid && (out_ch.data.status == tsp_pkg::ST_MISMATCH);
  assign out_ok       = out_ch.valid && (out_ch.data.status == tsp_pkg::ST_OK);
  assign csum_differs = out_ch.data.computed_checksum != out_ch.data.received_checksum;
  assign hdr_short    = (out_ch.data.segment_bytes < 16'd20) ||
                        (out_ch.data.data_offset < tsp_pkg::MIN_OFFSET);

  // A snapshot taken by the finishing stage shows up as a result next cycle.
  `TSP_ASSERT(a_snap_to_out, (snap_vld && snap_rdy) |=> out_ch.valid, "snapshot lost")

  // A mismatch status always comes with differing checksums.
  `TSP_ASSERT(a_mismatch, out_mismatch |-> csum_differs, "bad mismatch status")

  // An ok status means a full header was seen.
  `TSP_NEVER(a_ok_short, out_ok && hdr_short, "ok status on short header")

endmodule

// File: tb/tcp_segment_parse_checksum_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the TCP segment parser and checksum block.
// Depends on tsp_pkg, tsp_stream_if and tcp_segment_parse_checksum; a local
// word-by-word parser predicts each result beat, which is compared field by field.
module tcp_segment_parse_checksum_tb;

  localparam logic [31:0] MAX_SEG_BYTES = tsp_pkg::MAX_SEG_BYTES_DEF;

  // Values of the mode bit on the first word of a segment.
  localparam logic MODE_VERIFY   = 1'b0;
  localparam logic MODE_GENERATE = 1'b1;

  // Segment state of the local parser, cleared after every result.
  typedef struct packed {
    logic [15:0] acc;
    logic [31:0] nbytes;
    logic        v6;
    logic        gen;
    logic [31:0] ports;
    logic [63:0] seq_ack;
    logic [15:0] off_flags;
    logic [15:0] window;
    logic [15:0] csum;
    logic [15:0] urgent;
  } seg_state_t;

  logic clk = 1'b0;
  logic rst_n;

  tsp_stream_if #(.payload_t(tsp_pkg::in_item_t))  in_if ();
  tsp_stream_if #(.payload_t(tsp_pkg::out_item_t)) out_if ();

  tcp_segment_parse_checksum #(
    .MAX_SEGMENT_BYTES(MAX_SEG_BYTES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  seg_state_t          seg_model;
  tsp_pkg::out_item_t  pending_results[$];
  logic [15:0]         seg_words[$];
  bit                  stall_on;
  int                  failures;

  always #5 clk = ~clk;

  // Ones-complement add with the carry folded back into bit 0.
  function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return 16'(s + (s >> 16));
  endfunction

  // Advances the parser by one word; returns 1 when the word closes a segment.
  function automatic bit parse_word(inout seg_state_t st, input tsp_pkg::in_item_t it,
                                    output tsp_pkg::out_item_t res);
    logic [15:0] w;
    logic [31:0] step_bytes;
    logic [31:0] pos;
    logic [15:0] sum;
    logic [3:0]  offset;
    res = '0;
    w = it.data_word;
    step_bytes = 32'd2;
    if (st.nbytes == 32'd0) begin
      st.acc = it.pseudo_sum;
      st.v6  = it.ipv6;
      st.gen = it.mode;
    end
    // A lone tail byte sits in the high half; the low half is dropped.
    if (it.last && it.single_byte) begin
      step_bytes = 32'd1;
      w = {w[15:8], 8'h00};
    end
    pos = st.nbytes >> 1;
    case (pos)
      tsp_pkg::POS_SRC_PORT:  st.ports[31:16]   = w;
      tsp_pkg::POS_DST_PORT:  st.ports[15:0]    = w;
      tsp_pkg::POS_SEQ_HI:    st.seq_ack[63:48] = w;
      tsp_pkg::POS_SEQ_LO:    st.seq_ack[47:32] = w;
      tsp_pkg::POS_ACK_HI:    st.seq_ack[31:16] = w;
      tsp_pkg::POS_ACK_LO:    st.seq_ack[15:0]  = w;
      tsp_pkg::POS_OFF_FLAGS: st.off_flags      = w;
      tsp_pkg::POS_WINDOW:    st.window         = w;
      tsp_pkg::POS_CSUM:      st.csum           = w;
      tsp_pkg::POS_URGENT:    st.urgent         = w;
      default: ;
    endcase
    if (pos != tsp_pkg::POS_CSUM) st.acc = fold_add(st.acc, w);
    if (st.nbytes > 32'hffff_ffff - step_bytes) st.nbytes = 32'hffff_ffff;
    else st.nbytes = st.nbytes + step_bytes;
    if (!it.last) return 1'b0;

    // Close the segment: add the length, fold, complement and grade it.
    sum = fold_add(st.acc, st.nbytes[15:0]);
    if (st.v6) sum = fold_add(sum, st.nbytes[31:16]);
    offset = st.off_flags[15:12];
    res.computed_checksum = ~sum;
    if (st.nbytes > MAX_SEG_BYTES) res.status = tsp_pkg::ST_TOO_LONG;
    else if (st.nbytes < tsp_pkg::MIN_SEG_BYTES) res.status = tsp_pkg::ST_SHORT;
    else if (offset < tsp_pkg::MIN_OFFSET) res.status = tsp_pkg::ST_OFFSET;
    else if ({26'd0, offset, 2'b00} > st.nbytes) res.status = tsp_pkg::ST_HDR_PAST;
    else if (st.gen == MODE_VERIFY && ~sum != st.csum) res.status = tsp_pkg::ST_MISMATCH;
    else res.status = tsp_pkg::ST_OK;
    res.received_checksum = st.csum;
    res.source_port       = st.ports[31:16];
    res.dest_port         = st.ports[15:0];
    res.seq_number        = st.seq_ack[63:32];
    res.ack_number        = st.seq_ack[31:0];
    res.data_offset       = offset;
    res.flags             = st.off_flags[8:0];
    res.window_size       = st.window;
    res.urgent_pointer    = st.urgent;
    res.segment_bytes     = (st.nbytes > 32'h0000_ffff) ? 16'hffff : st.nbytes[15:0];
    st = '0;
    return 1'b1;
  endfunction

  // Builds the beat for word idx of seg_words. Fields that are only sampled on
  // the first word carry random junk on every later word.
  function automatic tsp_pkg::in_item_t make_item(input int idx, input logic mode,
                                                  input logic [15:0] psum, input logic v6,
                                                  input bit lone_tail, input bit stray_sb);
    tsp_pkg::in_item_t it;
    bit                is_last;
    is_last = (idx == seg_words.size() - 1);
    it.data_word   = seg_words[idx];
    it.last        = is_last;
    it.single_byte = is_last ? lone_tail : (stray_sb ? 1'($urandom_range(0, 1)) : 1'b0);
    if (idx == 0) begin
      it.mode       = mode;
      it.pseudo_sum = psum;
      it.ipv6       = v6;
    end else begin
      it.mode       = 1'($urandom_range(0, 1));
      it.pseudo_sum = 16'($urandom);
      it.ipv6       = 1'($urandom_range(0, 1));
    end
    return it;
  endfunction

  // Checksum that makes the current segment verify clean.
  function automatic logic [15:0] sealed_checksum(input logic [15:0] psum, input logic v6,
                                                  input bit lone_tail);
    seg_state_t         scratch;
    tsp_pkg::out_item_t r;
    scratch = '0;
    r = '0;
    for (int i = 0; i < seg_words.size(); i++)
      void'(parse_word(scratch, make_item(i, MODE_GENERATE, psum, v6, lone_tail, 1'b0), r));
    return r.computed_checksum;
  endfunction

  // Fixed 20-byte header followed by random payload words.
  task automatic build_header(input logic [15:0] src, input logic [15:0] dst,
                              input logic [31:0] seq, input logic [31:0] ack,
                              input logic [3:0] offset, input logic [8:0] flags,
                              input logic [15:0] window, input logic [15:0] urgent,
                              input int payload_words);
    seg_words.delete();
    seg_words.push_back(src);
    seg_words.push_back(dst);
    seg_words.push_back(seq[31:16]);
    seg_words.push_back(seq[15:0]);
    seg_words.push_back(ack[31:16]);
    seg_words.push_back(ack[15:0]);
    seg_words.push_back({offset, 3'($urandom), flags});
    seg_words.push_back(window);
    seg_words.push_back(16'($urandom));
    seg_words.push_back(urgent);
    repeat (payload_words) seg_words.push_back(16'($urandom));
  endtask

  task automatic fill_random(input int n);
    seg_words.delete();
    repeat (n) seg_words.push_back(16'($urandom));
  endtask

  // Sends one input beat and records the result it is expected to close.
  task automatic send_word(input tsp_pkg::in_item_t it);
    int                 gap;
    tsp_pkg::out_item_t res;
    gap = stall_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    if (parse_word(seg_model, it, res)) pending_results.push_back(res);
  endtask

  task automatic send_segment(input logic mode, input logic [15:0] psum, input logic v6,
                              input bit lone_tail, input bit stray_sb, input bit seal);
    if (seal && seg_words.size() > 8) seg_words[8] = sealed_checksum(psum, v6, lone_tail);
    for (int i = 0; i < seg_words.size(); i++)
      send_word(make_item(i, mode, psum, v6, lone_tail, stray_sb));
  endtask

  // Holds the input off until every predicted result has come out.
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  // Segments that end before the header does.
  task automatic test_short_segments();
    seg_words.delete();
    seg_words.push_back(16'hffff);
    send_segment(MODE_VERIFY, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0);
    fill_random(1);
    send_segment(MODE_VERIFY, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0);
    // Nine words: the urgent pointer word never arrives.
    fill_random(9);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b1, 1'b0, 1'b0, 1'b0);
    // Full header with a lone tail byte makes 19 bytes.
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd5, 9'($urandom),
                 16'($urandom), 16'($urandom), 0);
    send_segment(MODE_GENERATE, 16'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
  endtask

  // Data offset checks, in priority order against the length.
  task automatic test_header_checks();
    build_header(16'h0000, 16'h0000, 32'h0, 32'h0, 4'd0, 9'h000, 16'h0000, 16'h0000, 0);
    send_segment(MODE_GENERATE, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd4, 9'h1ff,
                 16'($urandom), 16'($urandom), 0);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b0, 1'b0, 1'b0, 1'b1);
    build_header(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 4'd15, 9'h1ff,
                 16'hffff, 16'hffff, 0);
    send_segment(MODE_GENERATE, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b0);
    // Offset 6 wants 24 bytes but only 23 arrive.
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd6, 9'($urandom),
                 16'($urandom), 16'($urandom), 2);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b0, 1'b1, 1'b0, 1'b1);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd15, 9'($urandom),
                 16'($urandom), 16'($urandom), 20);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b1, 1'b0, 1'b0, 1'b1);
  endtask

  // Verify and generate modes with good and bad checksum fields.
  task automatic test_checksum_modes();
    logic [15:0] psum;
    build_header(16'h0000, 16'h0000, 32'h0, 32'h0, 4'd5, 9'h000, 16'h0000, 16'h0000, 0);
    send_segment(MODE_VERIFY, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b1);
    build_header(16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 4'd5, 9'h1ff,
                 16'hffff, 16'hffff, 0);
    send_segment(MODE_VERIFY, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1);
    // A wrong checksum field is a mismatch only in verify mode.
    psum = 16'($urandom);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd5, 9'($urandom),
                 16'($urandom), 16'($urandom), 3);
    seg_words[8] = ~sealed_checksum(psum, 1'b0, 1'b1);
    send_segment(MODE_VERIFY, psum, 1'b0, 1'b1, 1'b0, 1'b0);
    send_segment(MODE_GENERATE, psum, 1'b0, 1'b1, 1'b0, 1'b0);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd6, 9'($urandom),
                 16'($urandom), 16'($urandom), 4);
    send_segment(MODE_GENERATE, 16'($urandom), 1'b1, 1'b1, 1'b0, 1'b0);
  endtask

  // single_byte on words other than the last must be ignored.
  task automatic test_stray_single_byte();
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd5, 9'($urandom),
                 16'($urandom), 16'($urandom), 6);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  // Longer segments sent back to back with no idle cycles on either side.
  task automatic test_long_segments();
    stall_on = 1'b0;
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd15, 9'($urandom),
                 16'($urandom), 16'($urandom), 24);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b1, 1'b1, 1'b0, 1'b1);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd5, 9'($urandom),
                 16'($urandom), 16'($urandom), 30);
    send_segment(MODE_VERIFY, 16'($urandom), 1'b1, 1'b0, 1'b0, 1'b1);
    build_header(16'($urandom), 16'($urandom), $urandom, $urandom, 4'd0, 9'($urandom),
                 16'($urandom), 16'($urandom), 26);
    send_segment(MODE_GENERATE, 16'($urandom), 1'b0, 1'b1, 1'b0, 1'b0);
    stall_on = 1'b1;
  endtask

  // Mostly well-formed segments with random content, the rest noise.
  task automatic test_random_traffic();
    int   sent;
    int   payload;
    int   max_off;
    bit   lone;
    bit   drained;
    logic mode;
    sent = 0;
    drained = 1'b0;
    while (sent < 280) begin
      stall_on = ($urandom_range(0, 3) != 0);
      mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 4) != 0) begin
        payload = $urandom_range(0, 20);
        lone = (payload > 0) ? 1'($urandom_range(0, 1)) : 1'b0;
        max_off = (20 + 2 * payload - int'(lone)) / 4;
        if (max_off > 15) max_off = 15;
        build_header(16'($urandom), 16'($urandom), $urandom, $urandom,
                     4'($urandom_range(5, max_off)), 9'($urandom), 16'($urandom),
                     16'($urandom), payload);
        send_segment(mode, 16'($urandom), 1'($urandom_range(0, 1)), lone, 1'b1,
                     $urandom_range(0, 9) != 0);
      end else begin
        fill_random($urandom_range(1, 24));
        send_segment(mode, 16'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)));
      end
      sent += seg_words.size();
      if (!drained && sent > 140) begin
        wait_for_results();
        drained = 1'b1;
      end
    end
  endtask

  // Result side: random stalls, then compare each beat with the oldest prediction.
  initial begin : result_sink
    int                 gap;
    tsp_pkg::out_item_t got;
    tsp_pkg::out_item_t want;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = stall_on ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (out_if.valid !== 1'b1) @(posedge clk);
      got = out_if.data;
      if (pending_results.size() == 0) begin
        $error("result beat with no segment pending");
        failures++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("computed_checksum", 32'(want.computed_checksum),
                    32'(got.computed_checksum));
        check_field("received_checksum", 32'(want.received_checksum),
                    32'(got.received_checksum));
        check_field("source_port", 32'(want.source_port), 32'(got.source_port));
        check_field("dest_port", 32'(want.dest_port), 32'(got.dest_port));
        check_field("seq_number", want.seq_number, got.seq_number);
        check_field("ack_number", want.ack_number, got.ack_number);
        check_field("data_offset", 32'(want.data_offset), 32'(got.data_offset));
        check_field("flags", 32'(want.flags), 32'(got.flags));
        check_field("window_size", 32'(want.window_size), 32'(got.window_size));
        check_field("urgent_pointer", 32'(want.urgent_pointer), 32'(got.urgent_pointer));
        check_field("segment_bytes", 32'(want.segment_bytes), 32'(got.segment_bytes));
      end
    end
  end

  // Hang guard, far beyond the slowest passing run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    failures = 0;
    stall_on = 1'b1;
    seg_model = '0;
    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_segments();
    test_header_checks();
    test_checksum_modes();
    test_stray_single_byte();
    test_long_segments();
    test_random_traffic();

    // Drain the pipeline, then wait for any stray beat.
    wait_for_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
